[rtl/cnf_pkg.sv]
// Shared types, character constants and lookup functions for the console
// number formatter. No dependencies.
package cnf_pkg;

   localparam logic [1:0] ACT_CHAR     = 2'd0;
   localparam logic [1:0] ACT_HEX      = 2'd1;
   localparam logic [1:0] ACT_HEX_LINE = 2'd2;
   localparam logic [1:0] ACT_DEC      = 2'd3;

   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_ALPHA_OFS = 8'h41 - 8'd10;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;

   localparam logic [3:0] IDX_LAST     = 4'd9;
   localparam logic [3:0] IDX_CR_LINE  = 4'd8;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib & 4'hF};
      return (nib < 4'd10) ? (CH_ZERO + wide) : (CH_ALPHA_OFS + wide);
   endfunction

   // Power of ten for digit position idx, most significant position first.
   function automatic logic [31:0] pow10(input logic [3:0] idx);
      logic [31:0] p;
      unique case (idx)
         4'd0:    p = 32'd1000000000;
         4'd1:    p = 32'd100000000;
         4'd2:    p = 32'd10000000;
         4'd3:    p = 32'd1000000;
         4'd4:    p = 32'd100000;
         4'd5:    p = 32'd10000;
         4'd6:    p = 32'd1000;
         4'd7:    p = 32'd100;
         4'd8:    p = 32'd10;
         default: p = 32'd1;
      endcase
      return p;
   endfunction

endpackage

[rtl/console_number_formatter_core.sv]
// Top level of the console number formatter: item register plus byte
// generator (cnf_seq) feeding the result register (cnf_out). Uses cnf_pkg.
//
// Usage:
//   The req channel takes one word per item: req_tuser selects the action
//   (char, "0x" hex, hex plus CR LF, unsigned decimal) and req_tdata holds
//   the 32-bit value. The rsp channel returns one ASCII byte per word, with
//   rsp_tlast marking the final byte of each item.
//   An item yields 1 or 2 bytes (char), 10 bytes (both hex forms) or 1 to
//   10 bytes (decimal). While the receiver does not stall, the byte generator
//   emits one byte per cycle, decimal digits one per cycle from the position
//   weight compare; the next item is taken in the cycle its predecessor's
//   last byte is generated. The first byte passes the item register and
//   then the result register on its way to rsp. When the receiver stalls,
//   the result register holds its word and the generator freezes behind it;
//   req_tready stays high then only while no item is held. Nothing is dropped.
//   Reset (synchronous, active high) empties both the item register and
//   the result register; no item is in flight afterwards.
module console_number_formatter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast
);

   logic              advance;
   logic              byte_valid;
   cnf_pkg::byte_type byte_word;

   cnf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_value  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_out   (byte_word)
   );

   cnf_out u_out (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_in    (byte_word),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/cnf_seq.sv]
// Item register and byte generator: holds one accepted word and produces
// one output byte per advance. Depends on cnf_pkg.
module cnf_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_action,
   input  logic [31:0]       req_value,
   input  logic              advance,
   output logic              byte_valid,
   output cnf_pkg::byte_type byte_out
);

   logic        busy_ff, busy_in;
   logic [1:0]  act_ff, act_in;
   logic [31:0] val_ff, val_in;
   logic [3:0]  idx_ff, idx_in;

   logic        accept;
   logic        step_last;
   logic [3:0]  start_idx;
   logic [3:0]  dec_digit;
   logic [31:0] dec_rem;
   logic [7:0]  gen_data;
   logic [31:0] val_step;

   // Start position: char skips CR unless it is LF; decimal skips leading zeros.
   always_comb begin
      logic [3:0] big_cnt;
      big_cnt = '0;
      for (int i = 1; i <= 9; i++) begin
         if (req_value >= cnf_pkg::pow10(4'(9 - i))) begin
            big_cnt = big_cnt + 4'd1;
         end
      end
      unique case (req_action)
         cnf_pkg::ACT_CHAR: start_idx = (req_value[7:0] == cnf_pkg::CH_LF) ? 4'd0 : 4'd1;
         cnf_pkg::ACT_DEC:  start_idx = cnf_pkg::IDX_LAST - big_cnt;
         default:           start_idx = 4'd0;
      endcase
   end

   // One decimal digit: compare against the nine multiples of the position weight.
   always_comb begin
      logic [35:0] p_wide;
      logic [35:0] mk;
      logic [35:0] v_wide;
      p_wide    = {4'b0000, cnf_pkg::pow10(idx_ff)};
      v_wide    = {4'b0000, val_ff};
      dec_digit = '0;
      dec_rem   = val_ff;
      for (int k = 1; k <= 9; k++) begin
         mk = p_wide * 36'(k);
         if (v_wide >= mk) begin
            dec_digit = 4'(k);
            dec_rem   = 32'(v_wide - mk);
         end
      end
   end

   always_comb begin
      gen_data  = cnf_pkg::CH_ZERO;
      val_step  = val_ff;
      step_last = (idx_ff == cnf_pkg::IDX_LAST);
      unique case (act_ff)
         cnf_pkg::ACT_CHAR: begin
            gen_data  = idx_ff[0] ? val_ff[7:0] : cnf_pkg::CH_CR;
            step_last = idx_ff[0];
         end
         cnf_pkg::ACT_HEX: begin
            if (idx_ff == 4'd0) begin
               gen_data = cnf_pkg::CH_ZERO;
            end else if (idx_ff == 4'd1) begin
               gen_data = cnf_pkg::CH_X;
            end else begin
               gen_data = cnf_pkg::hex_char(val_ff[31:28]);
               val_step = {val_ff[27:0], 4'b0000};
            end
         end
         cnf_pkg::ACT_HEX_LINE: begin
            if (idx_ff < cnf_pkg::IDX_CR_LINE) begin
               gen_data = cnf_pkg::hex_char(val_ff[31:28]);
               val_step = {val_ff[27:0], 4'b0000};
            end else if (idx_ff == cnf_pkg::IDX_CR_LINE) begin
               gen_data = cnf_pkg::CH_CR;
            end else begin
               gen_data = cnf_pkg::CH_LF;
            end
         end
         default: begin
            gen_data = cnf_pkg::CH_ZERO + {4'b0000, dec_digit};
            val_step = dec_rem;
         end
      endcase
   end

   assign req_tready = !busy_ff || (advance && step_last);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in = busy_ff;
      act_in  = act_ff;
      val_in  = val_ff;
      idx_in  = idx_ff;
      if (accept) begin
         busy_in = 1'b1;
         act_in  = req_action;
         val_in  = req_value;
         idx_in  = start_idx;
      end else if (advance && busy_ff) begin
         busy_in = !step_last;
         val_in  = val_step;
         idx_in  = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      act_ff <= act_in;
      val_ff <= val_in;
      idx_ff <= idx_in;
   end

   assign byte_valid    = busy_ff;
   assign byte_out.data = gen_data;
   assign byte_out.last = step_last;

endmodule

[rtl/cnf_out.sv]
// Result register on the byte stream; parts the generator from receiver
// stalls. Depends on cnf_pkg.
module cnf_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  cnf_pkg::byte_type byte_in,
   output logic              advance,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   logic              valid_ff;
   cnf_pkg::byte_type word_ff;

   assign advance = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= byte_valid;
      end
      if (advance) begin
         word_ff <= byte_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff.data;
   assign rsp_tlast  = word_ff.last;

endmodule

[rtl/cnf_checker.sv]
// Port-level checker for console_number_formatter_core and its bind.
// Depends on cnf_pkg for character constants.
module cnf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic hex_upper;
   logic dec_char;

   assign dec_char  = (rsp_tdata >= cnf_pkg::CH_ZERO) && (rsp_tdata <= 8'h39);
   assign hex_upper = (rsp_tdata >= 8'h41) && (rsp_tdata <= 8'h46);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_first_byte: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("no byte two cycles after an accepted word");

   a_inner_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> dec_char || hex_upper
         || (rsp_tdata == cnf_pkg::CH_X) || (rsp_tdata == cnf_pkg::CH_CR))
      else $error("unexpected byte before the last one");

endmodule

bind console_number_formatter_core cnf_checker u_cnf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
